@@ hdl/assert_macros.svh @@
// Assertion helpers for the clipper RTL. Each macro samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in %m");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in %m");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/rpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the rectangle polygon clipper.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int NUM_STAGES = 4;

  // Cell sequencer states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EVAL,
    CS_MUL,
    CS_DIV,
    CS_EMIT_X,
    CS_EMIT_P,
    CS_FWD
  } cell_state_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_XMIN = 2'd0,
    REG_XMAX = 2'd1,
    REG_YMIN = 2'd2,
    REG_YMAX = 2'd3
  } cfg_reg_e;

  // Token kind carried with every item between cells
  typedef struct packed {
    logic vtx;    // item carries a vertex
    logic close;  // item closes the polygon
  } tok_t;

  // Stage 0 and 2 test x against a vertical boundary
  function automatic logic stage_vert(input int st);
    return (st == 0) || (st == 2);
  endfunction

  // Stage 0 and 3 keep points at or above the boundary
  function automatic logic stage_ge(input int st);
    return (st == 0) || (st == 3);
  endfunction

endpackage

@@ hdl/rect_polygon_clipper.sv @@
// Rectangle polygon clipper. Vertices enter one item at a time with tlast on
// the final vertex; four clip cells (left, top, right, bottom) follow in a
// chain and each hands its items to the next. A cell only stores the first
// vertex of a polygon. On a later vertex it tests the edge from the previous
// vertex and emits nothing when the edge stays outside its boundary and the
// vertex when the edge ends inside. An edge that crosses goes through the
// multiply and the bit-serial divider of that cell, and the crossing point
// comes out first. Closing a polygon runs one more edge per cell, then the
// close item is passed on. Cells overlap, so the slowest cell on a given item
// sets the rate. Results come out one vertex late so the final one carries
// tlast; a polygon clipped away entirely yields one item with tuser set.
// ----------------------------------------------------------------------------
// rect_polygon_clipper
// Sutherland-Hodgman clip of a vertex stream against a configurable window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rect_polygon_clipper #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  // vertex input
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // fields from bit 0: vert_x, vert_y, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,   // vert_last
  // result output
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // fields from bit 0: out_x, out_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,   // out_last
  output logic                  m_axis_tuser_o    // out_empty
);

  localparam int CB = COORD_BITS;
  localparam int DW = ((2 * CB + 7) / 8) * 8;
  localparam int NS = rpc_pkg::NUM_STAGES;

  logic signed [CB-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [CB-1:0] bound [NS];

  logic [NS:0]          vld, rdy;
  logic signed [CB-1:0] cx [NS+1];
  logic signed [CB-1:0] cy [NS+1];
  rpc_pkg::tok_t        ctok [NS+1];

  logic signed [CB-1:0] res_x, res_y;
  logic                 res_last, res_empty;

  // Window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xmin_q <= CB'(20);
      xmax_q <= CB'(80);
      ymin_q <= CB'(10);
      ymax_q <= CB'(80);
    end else if (cfg_we_i) begin
      unique case (rpc_pkg::cfg_reg_e'(cfg_idx_i))
        rpc_pkg::REG_XMIN: xmin_q <= cfg_data_i;
        rpc_pkg::REG_XMAX: xmax_q <= cfg_data_i;
        rpc_pkg::REG_YMIN: ymin_q <= cfg_data_i;
        rpc_pkg::REG_YMAX: ymax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Boundary of each cell: left, top, right, bottom
  assign bound[0] = xmin_q;
  assign bound[1] = ymax_q;
  assign bound[2] = xmax_q;
  assign bound[3] = ymin_q;

  // Input item enters the chain as a vertex, closing when tlast is set
  assign vld[0]          = s_axis_tvalid_i;
  assign s_axis_tready_o = rdy[0];
  assign cx[0]           = s_axis_tdata_i[CB-1:0];
  assign cy[0]           = s_axis_tdata_i[2*CB-1:CB];
  assign ctok[0]         = '{vtx: 1'b1, close: s_axis_tlast_i};

  // Chain of clip cells
  for (genvar g = 0; g < NS; g++) begin : g_cell
    rpc_cell #(.CB(CB), .STAGE(g)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bound_i     (bound[g]),
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .in_x_i      (cx[g]),
      .in_y_i      (cy[g]),
      .in_tok_i    (ctok[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .out_x_o     (cx[g+1]),
      .out_y_o     (cy[g+1]),
      .out_tok_o   (ctok[g+1])
    );
  end

  // One-deep output hold
  rpc_hold #(.CB(CB)) u_hold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld[NS]),
    .in_ready_o  (rdy[NS]),
    .in_x_i      (cx[NS]),
    .in_y_i      (cy[NS]),
    .in_tok_i    (ctok[NS]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_x_o     (res_x),
    .out_y_o     (res_y),
    .out_last_o  (res_last),
    .out_empty_o (res_empty)
  );

  assign m_axis_tdata_o = DW'({res_y, res_x});
  assign m_axis_tlast_o = res_last;
  assign m_axis_tuser_o = res_empty;

  // The empty marker is always the final item of its polygon with zero data
  `ASSERT_IMP(a_empty_is_last, m_axis_tvalid_o && m_axis_tuser_o,
              m_axis_tlast_o && (res_x == '0) && (res_y == '0))
  // A closing vertex leaves the first cell busy in the cycle after its acceptance
  `ASSERT_NXT(a_close_busy, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i,
              !s_axis_tready_o)

endmodule

@@ hdl/rpc_cell.sv @@
// ----------------------------------------------------------------------------
// rpc_cell
// One clip stage: keeps first and previous vertex, emits crossing and inside
// vertex per edge, closes the polygon on a close token.
// ----------------------------------------------------------------------------
module rpc_cell #(
  parameter int CB    = 16,
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic signed [CB-1:0] bound_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [CB-1:0] in_x_i,
  input  logic signed [CB-1:0] in_y_i,
  input  rpc_pkg::tok_t        in_tok_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [CB-1:0] out_x_o,
  output logic signed [CB-1:0] out_y_o,
  output rpc_pkg::tok_t        out_tok_o
);

  localparam logic VERT = rpc_pkg::stage_vert(STAGE);
  localparam logic GE   = rpc_pkg::stage_ge(STAGE);
  localparam int   PW   = 2 * CB + 2;
  localparam int   CW   = $clog2(PW);
  localparam logic [CW-1:0] CNT_LAST = CW'(PW - 1);

  rpc_pkg::cell_state_e state_q, state_d;

  logic signed [CB-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CB-1:0] s_x_q, s_y_q, p_x_q, p_y_q;
  logic                 seen_q, close_pend_q, fwd_q;
  logic [CB:0]          a_q, b_q, den_q;
  logic                 neg_q, pin_q;
  logic [PW-1:0]        dq_q;
  logic [CB+1:0]        rem_q;
  logic [CW-1:0]        cnt_q;
  logic                 out_valid_q;
  logic signed [CB-1:0] out_x_q, out_y_q;
  rpc_pkg::tok_t        out_tok_q;

  logic                 out_free, go_after, load_out;
  logic signed [CB-1:0] ld_x, ld_y;
  rpc_pkg::tok_t        ld_tok;
  logic                 pin, sin;
  logic signed [CB:0]   num, tt, den;
  logic [CB:0]          num_m, tt_m, den_m;
  logic [CB+1:0]        rem2;
  logic                 ge;
  logic [CB-1:0]        q, qs;

  assign out_free = !out_valid_q || out_ready_i;

  // Half-plane tests and crossing operands on the current edge s -> p
  always_comb begin
    if (VERT) begin
      pin = GE ? (p_x_q >= bound_i) : (p_x_q <= bound_i);
      sin = GE ? (s_x_q >= bound_i) : (s_x_q <= bound_i);
      num = (CB+1)'(p_y_q) - (CB+1)'(s_y_q);
      tt  = (CB+1)'(bound_i) - (CB+1)'(s_x_q);
      den = (CB+1)'(p_x_q) - (CB+1)'(s_x_q);
    end else begin
      pin = GE ? (p_y_q >= bound_i) : (p_y_q <= bound_i);
      sin = GE ? (s_y_q >= bound_i) : (s_y_q <= bound_i);
      num = (CB+1)'(p_x_q) - (CB+1)'(s_x_q);
      tt  = (CB+1)'(bound_i) - (CB+1)'(s_y_q);
      den = (CB+1)'(p_y_q) - (CB+1)'(s_y_q);
    end
    num_m = num[CB] ? -num : num;
    tt_m  = tt[CB]  ? -tt  : tt;
    den_m = den[CB] ? -den : den;
  end

  // Restoring divider step, one quotient bit a cycle
  always_comb begin
    rem2 = {rem_q[CB:0], dq_q[PW-1]};
    ge   = rem2 >= {1'b0, den_q};
    q    = (den_q == '0) ? '0 : dq_q[CB-1:0];
    qs   = neg_q ? -q : q;
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    go_after = 1'b0;
    unique case (state_q)
      rpc_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          if (in_tok_i.vtx && !seen_q && !in_tok_i.close) state_d = rpc_pkg::CS_IDLE;
          else if (!in_tok_i.vtx && !seen_q)            state_d = rpc_pkg::CS_FWD;
          else                                          state_d = rpc_pkg::CS_EVAL;
        end
      end
      rpc_pkg::CS_EVAL: begin
        if (pin != sin)  state_d = rpc_pkg::CS_MUL;
        else if (pin)    state_d = rpc_pkg::CS_EMIT_P;
        else             go_after = 1'b1;
      end
      rpc_pkg::CS_MUL: state_d = rpc_pkg::CS_DIV;
      rpc_pkg::CS_DIV: begin
        if (cnt_q == CNT_LAST) state_d = rpc_pkg::CS_EMIT_X;
      end
      rpc_pkg::CS_EMIT_X: begin
        if (out_free) begin
          if (pin_q) state_d = rpc_pkg::CS_EMIT_P;
          else       go_after = 1'b1;
        end
      end
      rpc_pkg::CS_EMIT_P: begin
        if (out_free) go_after = 1'b1;
      end
      rpc_pkg::CS_FWD: begin
        if (out_free) state_d = rpc_pkg::CS_IDLE;
      end
      default: state_d = rpc_pkg::CS_IDLE;
    endcase
    if (go_after) begin
      if (close_pend_q) state_d = rpc_pkg::CS_EVAL;
      else if (fwd_q)   state_d = rpc_pkg::CS_FWD;
      else              state_d = rpc_pkg::CS_IDLE;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    ld_x       = p_x_q;
    ld_y       = p_y_q;
    ld_tok     = '{vtx: 1'b1, close: 1'b0};
    unique case (state_q)
      rpc_pkg::CS_IDLE: in_ready_o = 1'b1;
      rpc_pkg::CS_EMIT_X: begin
        load_out = out_free;
        if (VERT) begin
          ld_x = bound_i;
          ld_y = s_y_q + $signed(qs);
        end else begin
          ld_x = s_x_q + $signed(qs);
          ld_y = bound_i;
        end
      end
      rpc_pkg::CS_EMIT_P: load_out = out_free;
      rpc_pkg::CS_FWD: begin
        load_out = out_free;
        ld_x     = '0;
        ld_y     = '0;
        ld_tok   = '{vtx: 1'b0, close: 1'b1};
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rpc_pkg::CS_IDLE;
      seen_q       <= 1'b0;
      close_pend_q <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rpc_pkg::CS_IDLE && in_valid_i) begin
        fwd_q <= in_tok_i.close;
        if (in_tok_i.vtx) begin
          seen_q       <= 1'b1;
          close_pend_q <= seen_q && in_tok_i.close;
        end else begin
          close_pend_q <= 1'b0;
        end
      end
      if (go_after && close_pend_q) close_pend_q <= 1'b0;
      if (state_q == rpc_pkg::CS_FWD && out_free) seen_q <= 1'b0;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Vertex store, edge operands, divider and output payload
  always_ff @(posedge clk_i) begin
    if (state_q == rpc_pkg::CS_IDLE && in_valid_i) begin
      if (in_tok_i.vtx) begin
        prev_x_q <= in_x_i;
        prev_y_q <= in_y_i;
        p_x_q    <= in_x_i;
        p_y_q    <= in_y_i;
        if (seen_q) begin
          s_x_q <= prev_x_q;
          s_y_q <= prev_y_q;
        end else begin
          first_x_q <= in_x_i;
          first_y_q <= in_y_i;
          s_x_q     <= in_x_i;
          s_y_q     <= in_y_i;
        end
      end else begin
        s_x_q <= prev_x_q;
        s_y_q <= prev_y_q;
        p_x_q <= first_x_q;
        p_y_q <= first_y_q;
      end
    end
    if (go_after && close_pend_q) begin
      s_x_q <= p_x_q;
      s_y_q <= p_y_q;
      p_x_q <= first_x_q;
      p_y_q <= first_y_q;
    end
    if (state_q == rpc_pkg::CS_EVAL) begin
      a_q   <= num_m;
      b_q   <= tt_m;
      den_q <= den_m;
      neg_q <= num[CB] ^ tt[CB] ^ den[CB];
      pin_q <= pin;
    end
    if (state_q == rpc_pkg::CS_MUL) begin
      dq_q  <= PW'(a_q * b_q);
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == rpc_pkg::CS_DIV) begin
      dq_q  <= {dq_q[PW-2:0], ge};
      rem_q <= ge ? (rem2 - {1'b0, den_q}) : rem2;
      cnt_q <= cnt_q + 1'b1;
    end
    if (load_out) begin
      out_x_q   <= ld_x;
      out_y_q   <= ld_y;
      out_tok_q <= ld_tok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_tok_o   = out_tok_q;

endmodule

@@ hdl/rpc_hold.sv @@
// ----------------------------------------------------------------------------
// rpc_hold
// Holds each clipped vertex back by one so the final one carries the last
// flag; turns an empty polygon into a single empty marker.
// ----------------------------------------------------------------------------
module rpc_hold #(
  parameter int CB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [CB-1:0] in_x_i,
  input  logic signed [CB-1:0] in_y_i,
  input  rpc_pkg::tok_t        in_tok_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [CB-1:0] out_x_o,
  output logic signed [CB-1:0] out_y_o,
  output logic                 out_last_o,
  output logic                 out_empty_o
);

  logic                 hold_v_q, out_valid_q, out_last_q, out_empty_q;
  logic signed [CB-1:0] hold_x_q, hold_y_q, out_x_q, out_y_q;
  logic                 acc, load_out;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign load_out   = acc && (in_tok_i.close || hold_v_q);

  // Control: hold flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) hold_v_q <= !in_tok_i.close;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload: held vertex and output item
  always_ff @(posedge clk_i) begin
    if (acc && !in_tok_i.close) begin
      hold_x_q <= in_x_i;
      hold_y_q <= in_y_i;
    end
    if (load_out) begin
      out_x_q     <= hold_v_q ? hold_x_q : '0;
      out_y_q     <= hold_v_q ? hold_y_q : '0;
      out_last_q  <= in_tok_i.close;
      out_empty_q <= in_tok_i.close && !hold_v_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

endmodule
